// File: rtl/flha_pkg.sv
// Shared types and constants for the free-list heap allocator.
package flha_pkg;

  localparam int OFS_W = 20;
  localparam int LIM_W = 21;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 21'd1048576;
  localparam logic [31:0] MIN_BLOCK = 32'd24;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;
  localparam logic [1:0] OP_INIT    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE, S_OUT, S_BOOT, S_TOP_ALLOC, S_TOP_FREE, S_TOP_INIT, S_TOP_PTR,
    S_ST0, S_ST1,
    S_PU0, S_PU1, S_PU2,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4, S_RM5,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG_SET, S_MG_PUSH,
    S_GR0, S_GR1, S_GR2,
    S_BF0, S_BF1, S_BF2,
    S_PL0, S_PL1, S_PL2, S_PL3, S_PL4,
    S_AL0, S_AL1, S_AL2, S_AL3, S_AL4,
    S_RL0, S_RL1, S_RL2,
    S_IN0, S_IN1, S_IN2, S_IN3, S_IN4, S_IN5,
    S_RA0, S_RA1, S_RA2, S_RA3, S_RA4, S_RA5, S_RA6, S_RA7, S_RA8, S_RA9, S_RA10
  } state_t;

endpackage

// File: rtl/flha_ram.sv
// Single-port synchronous RAM with registered read.
module flha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/free_list_heap_allocator_core.sv
// Heap allocator: boundary-tag heap in one RAM, walked by a microsequencer.
// One request in flight at a time; an allocate walks the free list for a best fit.
// The single RAM port (one read or one write a cycle) sets the step count.
// Reset: synchronous; afterwards the sequencer rebuilds the initial heap
//   before in_tready rises.
module free_list_heap_allocator_core #(
  parameter int HEAP_WORDS = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode, request_size, block_offset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_offset, status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int CAP = (4 * HEAP_WORDS < 1048576) ? 4 * HEAP_WORDS : 1048576;
  localparam int MAX_WALK = (4 * HEAP_WORDS) / 24 + 1;
  localparam int NW = $clog2(MAX_WALK + 1);

  function automatic logic [31:0] align8(input logic [31:0] x);
    align8 = (x + 32'd7) & ~32'd7;
  endfunction

  function automatic logic [31:0] adjust(input logic [31:0] x);
    logic [31:0] a;
    a = align8(x + 32'd8);
    adjust = (a < flha_pkg::MIN_BLOCK) ? flha_pkg::MIN_BLOCK : a;
  endfunction

  flha_pkg::state_t state_r, state_nxt;
  flha_pkg::state_t st_ret_r, st_ret_nxt, pu_ret_r, pu_ret_nxt, rm_ret_r, rm_ret_nxt;
  flha_pkg::state_t mg_ret_r, mg_ret_nxt, gr_ret_r, gr_ret_nxt, pl_ret_r, pl_ret_nxt;
  flha_pkg::state_t al_ret_r, al_ret_nxt, rl_ret_r, rl_ret_nxt, in_ret_r, in_ret_nxt;

  logic [19:0] sz_r, sz_nxt, off_r, off_nxt;
  logic [20:0] brk_r, brk_nxt, lim_r, lim_nxt;
  logic [19:0] head_r, head_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [19:0] out_ofs_r, out_ofs_nxt, res_ofs_r, res_ofs_nxt;
  logic [1:0]  out_st_r, out_st_nxt, res_st_r, res_st_nxt;

  logic [31:0] st_bp_r, st_bp_nxt, st_size_r, st_size_nxt;
  logic        st_alloc_r, st_alloc_nxt;
  logic [31:0] pu_bp_r, pu_bp_nxt;
  logic [19:0] pu_old_r, pu_old_nxt;
  logic [31:0] rm_bp_r, rm_bp_nxt, rm_p_r, rm_p_nxt, rm_s_r, rm_s_nxt;
  logic [31:0] mg_bp_r, mg_bp_nxt, mg_pb_r, mg_pb_nxt, mg_nb_r, mg_nb_nxt;
  logic [31:0] mg_size_r, mg_size_nxt, mg_pbs_r, mg_pbs_nxt;
  logic        mg_pa_r, mg_pa_nxt;
  logic [31:0] gr_bp_r, gr_bp_nxt, gr_size_r, gr_size_nxt;
  logic        gr_ok_r, gr_ok_nxt;
  logic [31:0] bf_bp_r, bf_bp_nxt, bf_best_r, bf_best_nxt, bf_bests_r, bf_bests_nxt;
  logic [NW-1:0] bf_n_r, bf_n_nxt;
  logic [31:0] pl_bp_r, pl_bp_nxt, pl_asize_r, pl_asize_nxt, pl_bs_r, pl_bs_nxt;
  logic        pl_from_r, pl_from_nxt;
  logic [19:0] al_size_r, al_size_nxt;
  logic [31:0] al_asize_r, al_asize_nxt, al_bp_r, al_bp_nxt;
  logic        al_ok_r, al_ok_nxt;
  logic [31:0] rl_bp_r, rl_bp_nxt;
  logic        ini_ok_r, ini_ok_nxt;
  logic [31:0] ra_asize_r, ra_asize_nxt, ra_old_r, ra_old_nxt, ra_nb_r, ra_nb_nxt;
  logic [31:0] ra_ns_r, ra_ns_nxt, ra_np_r, ra_np_nxt;
  logic        ra_na_r, ra_na_nxt;

  logic          mem_we;
  logic [31:0]   mem_ba, mem_wdata, mem_q;
  logic [AW-1:0] mem_addr;
  logic [31:0]   q_sz, ptr, bf_nb, al_last, st_tag, eff32;
  logic [20:0]   eff;
  logic [1:0]    in_op;
  logic [NW-1:0] bf_n_inc;
  logic [32:0]   gr_end;
  logic [31:0]   gr_al;
  logic          cfg_wr;

  assign q_sz = {mem_q[31:3], 3'b000};
  assign ptr = {12'd0, off_r};
  assign eff = (lim_r > 21'(CAP)) ? 21'(CAP) : lim_r;
  assign eff32 = {11'd0, eff};
  assign st_tag = {st_size_r[31:3], 2'b00, st_alloc_r};
  assign al_last = {11'd0, brk_r} - q_sz;
  assign bf_n_inc = bf_n_r + 1'b1;
  assign bf_nb = mem_q;
  assign gr_al = align8(gr_size_r);
  assign gr_end = {12'd0, brk_r} + {1'b0, gr_al};
  assign mem_addr = AW'(mem_ba[31:2] % 30'(HEAP_WORDS));
  assign in_op = (in_tdata[1:0] == flha_pkg::OP_REALLOC && in_tdata[41:22] == 20'd0)
                 ? flha_pkg::OP_ALLOC : in_tdata[1:0];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  assign in_tready = (state_r == flha_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_st_r, out_ofs_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {11'd0, lim_r};

  flha_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  always_comb begin
    state_nxt = state_r;
    st_ret_nxt = st_ret_r; pu_ret_nxt = pu_ret_r; rm_ret_nxt = rm_ret_r;
    mg_ret_nxt = mg_ret_r; gr_ret_nxt = gr_ret_r; pl_ret_nxt = pl_ret_r;
    al_ret_nxt = al_ret_r; rl_ret_nxt = rl_ret_r; in_ret_nxt = in_ret_r;
    sz_nxt = sz_r; off_nxt = off_r; brk_nxt = brk_r; lim_nxt = lim_r; head_nxt = head_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_ofs_nxt = out_ofs_r; out_st_nxt = out_st_r;
    res_ofs_nxt = res_ofs_r; res_st_nxt = res_st_r;
    st_bp_nxt = st_bp_r; st_size_nxt = st_size_r; st_alloc_nxt = st_alloc_r;
    pu_bp_nxt = pu_bp_r; pu_old_nxt = pu_old_r;
    rm_bp_nxt = rm_bp_r; rm_p_nxt = rm_p_r; rm_s_nxt = rm_s_r;
    mg_bp_nxt = mg_bp_r; mg_pb_nxt = mg_pb_r; mg_nb_nxt = mg_nb_r;
    mg_size_nxt = mg_size_r; mg_pbs_nxt = mg_pbs_r; mg_pa_nxt = mg_pa_r;
    gr_bp_nxt = gr_bp_r; gr_size_nxt = gr_size_r; gr_ok_nxt = gr_ok_r;
    bf_bp_nxt = bf_bp_r; bf_best_nxt = bf_best_r; bf_bests_nxt = bf_bests_r;
    bf_n_nxt = bf_n_r;
    pl_bp_nxt = pl_bp_r; pl_asize_nxt = pl_asize_r; pl_bs_nxt = pl_bs_r;
    pl_from_nxt = pl_from_r;
    al_size_nxt = al_size_r; al_asize_nxt = al_asize_r; al_bp_nxt = al_bp_r;
    al_ok_nxt = al_ok_r;
    rl_bp_nxt = rl_bp_r; ini_ok_nxt = ini_ok_r;
    ra_asize_nxt = ra_asize_r; ra_old_nxt = ra_old_r; ra_nb_nxt = ra_nb_r;
    ra_ns_nxt = ra_ns_r; ra_np_nxt = ra_np_r; ra_na_nxt = ra_na_r;
    mem_we = 1'b0; mem_ba = 32'd0; mem_wdata = 32'd0;

    if (cfg_wr && !cfg_paddr[2]) begin
      lim_nxt = cfg_pwdata[20:0];
    end

    case (state_r)
      flha_pkg::S_IDLE: begin
        if (in_tvalid) begin
          sz_nxt = in_tdata[21:2];
          off_nxt = in_tdata[41:22];
          case (in_op)
            flha_pkg::OP_ALLOC: begin
              if (in_tdata[21:2] == 20'd0) begin
                res_ofs_nxt = 20'd0; res_st_nxt = flha_pkg::ST_NULL;
                state_nxt = flha_pkg::S_OUT;
              end else begin
                al_size_nxt = in_tdata[21:2];
                al_ret_nxt = flha_pkg::S_TOP_ALLOC;
                state_nxt = flha_pkg::S_AL0;
              end
            end
            flha_pkg::OP_FREE: begin
              if (in_tdata[41:22] == 20'd0) begin
                res_ofs_nxt = 20'd0; res_st_nxt = flha_pkg::ST_NULL;
                state_nxt = flha_pkg::S_OUT;
              end else begin
                rl_bp_nxt = {12'd0, in_tdata[41:22]};
                rl_ret_nxt = flha_pkg::S_TOP_FREE;
                state_nxt = flha_pkg::S_RL0;
              end
            end
            flha_pkg::OP_REALLOC: state_nxt = flha_pkg::S_RA0;
            default: begin
              in_ret_nxt = flha_pkg::S_TOP_INIT;
              state_nxt = flha_pkg::S_IN0;
            end
          endcase
        end
      end
      flha_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ofs_nxt = res_ofs_r;
          out_st_nxt = res_st_r;
          state_nxt = flha_pkg::S_IDLE;
        end
      end
      flha_pkg::S_BOOT: state_nxt = flha_pkg::S_IDLE;
      flha_pkg::S_TOP_ALLOC: begin
        res_ofs_nxt = al_ok_r ? al_bp_r[19:0] : 20'd0;
        res_st_nxt = al_ok_r ? flha_pkg::ST_OK : flha_pkg::ST_OOM;
        state_nxt = flha_pkg::S_OUT;
      end
      flha_pkg::S_TOP_FREE: begin
        res_ofs_nxt = 20'd0; res_st_nxt = flha_pkg::ST_OK;
        state_nxt = flha_pkg::S_OUT;
      end
      flha_pkg::S_TOP_INIT: begin
        res_ofs_nxt = 20'd0;
        res_st_nxt = ini_ok_r ? flha_pkg::ST_OK : flha_pkg::ST_OOM;
        state_nxt = flha_pkg::S_OUT;
      end
      flha_pkg::S_TOP_PTR: begin
        res_ofs_nxt = off_r; res_st_nxt = flha_pkg::ST_OK;
        state_nxt = flha_pkg::S_OUT;
      end

      // header and footer tags
      flha_pkg::S_ST0: begin
        mem_we = 1'b1; mem_ba = st_bp_r - 32'd4; mem_wdata = st_tag;
        state_nxt = flha_pkg::S_ST1;
      end
      flha_pkg::S_ST1: begin
        mem_we = 1'b1; mem_wdata = st_tag;
        mem_ba = st_bp_r + {st_size_r[31:3], 3'b000} - 32'd8;
        state_nxt = st_ret_r;
      end

      // push on free list head
      flha_pkg::S_PU0: begin
        pu_old_nxt = head_r;
        head_nxt = pu_bp_r[19:0];
        mem_we = 1'b1; mem_ba = pu_bp_r + 32'd4; mem_wdata = {12'd0, head_r};
        state_nxt = flha_pkg::S_PU1;
      end
      flha_pkg::S_PU1: begin
        mem_we = 1'b1; mem_ba = pu_bp_r;
        state_nxt = (pu_old_r == 20'd0) ? pu_ret_r : flha_pkg::S_PU2;
      end
      flha_pkg::S_PU2: begin
        mem_we = 1'b1; mem_ba = {12'd0, pu_old_r}; mem_wdata = pu_bp_r;
        state_nxt = pu_ret_r;
      end

      // unlink from free list
      flha_pkg::S_RM0: begin
        mem_ba = rm_bp_r;
        state_nxt = flha_pkg::S_RM1;
      end
      flha_pkg::S_RM1: begin
        rm_p_nxt = mem_q;
        mem_ba = rm_bp_r + 32'd4;
        state_nxt = flha_pkg::S_RM2;
      end
      flha_pkg::S_RM2: begin
        rm_s_nxt = mem_q;
        if (rm_p_r != 32'd0) begin
          mem_we = 1'b1; mem_ba = rm_p_r + 32'd4; mem_wdata = mem_q;
        end else begin
          head_nxt = mem_q[19:0];
        end
        state_nxt = flha_pkg::S_RM3;
      end
      flha_pkg::S_RM3: begin
        if (rm_s_r != 32'd0) begin
          mem_we = 1'b1; mem_ba = rm_s_r; mem_wdata = rm_p_r;
        end
        state_nxt = flha_pkg::S_RM4;
      end
      flha_pkg::S_RM4: begin
        mem_we = 1'b1; mem_ba = rm_bp_r;
        state_nxt = flha_pkg::S_RM5;
      end
      flha_pkg::S_RM5: begin
        mem_we = 1'b1; mem_ba = rm_bp_r + 32'd4;
        state_nxt = rm_ret_r;
      end

      // coalesce with neighbors, then push
      flha_pkg::S_MG0: begin
        mem_ba = mg_bp_r - 32'd8;
        state_nxt = flha_pkg::S_MG1;
      end
      flha_pkg::S_MG1: begin
        mg_pb_nxt = mg_bp_r - q_sz;
        mem_ba = mg_bp_r - 32'd4;
        state_nxt = flha_pkg::S_MG2;
      end
      flha_pkg::S_MG2: begin
        mg_size_nxt = q_sz;
        mg_nb_nxt = mg_bp_r + q_sz;
        mem_ba = mg_pb_r - 32'd4;
        state_nxt = flha_pkg::S_MG3;
      end
      flha_pkg::S_MG3: begin
        mg_pa_nxt = mem_q[0];
        mg_pbs_nxt = q_sz;
        mem_ba = mg_nb_r - 32'd4;
        state_nxt = flha_pkg::S_MG4;
      end
      flha_pkg::S_MG4: begin
        if (!mg_pa_r && mem_q[0]) begin
          mg_size_nxt = mg_size_r + mg_pbs_r;
          rm_bp_nxt = mg_pb_r; rm_ret_nxt = flha_pkg::S_MG_SET;
          mg_bp_nxt = mg_pb_r;
          state_nxt = flha_pkg::S_RM0;
        end else if (mg_pa_r && !mem_q[0]) begin
          mg_size_nxt = mg_size_r + q_sz;
          rm_bp_nxt = mg_nb_r; rm_ret_nxt = flha_pkg::S_MG_SET;
          state_nxt = flha_pkg::S_RM0;
        end else if (!mg_pa_r && !mem_q[0]) begin
          mg_size_nxt = mg_size_r + mg_pbs_r + q_sz;
          rm_bp_nxt = mg_pb_r; rm_ret_nxt = flha_pkg::S_MG5;
          mg_bp_nxt = mg_pb_r;
          state_nxt = flha_pkg::S_RM0;
        end else begin
          state_nxt = flha_pkg::S_MG_PUSH;
        end
      end
      flha_pkg::S_MG5: begin
        rm_bp_nxt = mg_nb_r; rm_ret_nxt = flha_pkg::S_MG_SET;
        state_nxt = flha_pkg::S_RM0;
      end
      flha_pkg::S_MG_SET: begin
        st_bp_nxt = mg_bp_r; st_size_nxt = mg_size_r; st_alloc_nxt = 1'b0;
        st_ret_nxt = flha_pkg::S_MG_PUSH;
        state_nxt = flha_pkg::S_ST0;
      end
      flha_pkg::S_MG_PUSH: begin
        pu_bp_nxt = mg_bp_r; pu_ret_nxt = mg_ret_r;
        state_nxt = flha_pkg::S_PU0;
      end

      // heap growth; new block ends up in mg_bp
      flha_pkg::S_GR0: begin
        if (gr_end > {1'b0, eff32}) begin
          gr_ok_nxt = 1'b0;
          state_nxt = gr_ret_r;
        end else begin
          gr_ok_nxt = 1'b1;
          gr_bp_nxt = {11'd0, brk_r};
          gr_size_nxt = gr_al;
          brk_nxt = gr_end[20:0];
          st_bp_nxt = {11'd0, brk_r}; st_size_nxt = gr_al; st_alloc_nxt = 1'b0;
          st_ret_nxt = flha_pkg::S_GR1;
          state_nxt = flha_pkg::S_ST0;
        end
      end
      flha_pkg::S_GR1: begin
        mem_we = 1'b1; mem_ba = gr_bp_r + gr_size_r - 32'd4; mem_wdata = 32'd1;
        state_nxt = flha_pkg::S_GR2;
      end
      flha_pkg::S_GR2: begin
        mg_bp_nxt = gr_bp_r; mg_ret_nxt = gr_ret_r;
        state_nxt = flha_pkg::S_MG0;
      end

      // best-fit walk; each node passes through BF1 then BF2
      flha_pkg::S_BF0: begin
        bf_bp_nxt = {12'd0, head_r};
        bf_best_nxt = 32'd0;
        bf_bests_nxt = 32'hFFFF_FFFF;
        bf_n_nxt = '0;
        if (head_r == 20'd0) begin
          state_nxt = flha_pkg::S_AL1;
        end else begin
          mem_ba = {12'd0, head_r} - 32'd4;
          state_nxt = flha_pkg::S_BF1;
        end
      end
      flha_pkg::S_BF1: begin
        if (al_asize_r <= q_sz && q_sz < bf_bests_r) begin
          bf_bests_nxt = q_sz;
          bf_best_nxt = bf_bp_r;
        end
        mem_ba = bf_bp_r + 32'd4;
        state_nxt = flha_pkg::S_BF2;
      end
      flha_pkg::S_BF2: begin
        bf_bp_nxt = bf_nb;
        bf_n_nxt = bf_n_inc;
        if (bf_nb != 32'd0 && bf_n_inc < NW'(MAX_WALK)) begin
          mem_ba = bf_nb - 32'd4;
          state_nxt = flha_pkg::S_BF1;
        end else begin
          state_nxt = flha_pkg::S_AL1;
        end
      end

      // place with optional split
      flha_pkg::S_PL0: begin
        if (pl_from_r) begin
          rm_bp_nxt = pl_bp_r; rm_ret_nxt = flha_pkg::S_PL1;
          state_nxt = flha_pkg::S_RM0;
        end else begin
          state_nxt = flha_pkg::S_PL1;
        end
      end
      flha_pkg::S_PL1: begin
        mem_ba = pl_bp_r - 32'd4;
        state_nxt = flha_pkg::S_PL2;
      end
      flha_pkg::S_PL2: begin
        pl_bs_nxt = q_sz;
        st_bp_nxt = pl_bp_r; st_alloc_nxt = 1'b1;
        state_nxt = flha_pkg::S_ST0;
        if ({1'b0, q_sz} >= {1'b0, pl_asize_r} + {1'b0, flha_pkg::MIN_BLOCK}) begin
          st_size_nxt = pl_asize_r; st_ret_nxt = flha_pkg::S_PL3;
        end else begin
          st_size_nxt = q_sz; st_ret_nxt = pl_ret_r;
        end
      end
      flha_pkg::S_PL3: begin
        st_bp_nxt = pl_bp_r + pl_asize_r; st_size_nxt = pl_bs_r - pl_asize_r;
        st_alloc_nxt = 1'b0; st_ret_nxt = flha_pkg::S_PL4;
        state_nxt = flha_pkg::S_ST0;
      end
      flha_pkg::S_PL4: begin
        pu_bp_nxt = pl_bp_r + pl_asize_r; pu_ret_nxt = pl_ret_r;
        state_nxt = flha_pkg::S_PU0;
      end

      // allocate
      flha_pkg::S_AL0: begin
        if (al_size_r == 20'd448) begin
          al_asize_nxt = adjust(32'd512);
        end else if (al_size_r == 20'd112) begin
          al_asize_nxt = adjust(32'd128);
        end else begin
          al_asize_nxt = adjust({12'd0, al_size_r});
        end
        state_nxt = flha_pkg::S_BF0;
      end
      flha_pkg::S_AL1: begin
        if (bf_best_r != 32'd0) begin
          al_bp_nxt = bf_best_r; al_ok_nxt = 1'b1;
          pl_bp_nxt = bf_best_r; pl_asize_nxt = al_asize_r; pl_from_nxt = 1'b1;
          pl_ret_nxt = al_ret_r;
          state_nxt = flha_pkg::S_PL0;
        end else begin
          mem_ba = {11'd0, brk_r} - 32'd8;
          state_nxt = flha_pkg::S_AL2;
        end
      end
      flha_pkg::S_AL2: begin
        mem_ba = al_last - 32'd4;
        state_nxt = flha_pkg::S_AL3;
      end
      flha_pkg::S_AL3: begin
        // last block free: grow only by the shortfall
        if (!mem_q[0] && q_sz < al_asize_r) begin
          gr_size_nxt = align8(al_asize_r - q_sz);
        end else begin
          gr_size_nxt = al_asize_r;
        end
        gr_ret_nxt = flha_pkg::S_AL4;
        state_nxt = flha_pkg::S_GR0;
      end
      flha_pkg::S_AL4: begin
        if (!gr_ok_r) begin
          al_ok_nxt = 1'b0; al_bp_nxt = 32'd0;
          state_nxt = al_ret_r;
        end else begin
          al_ok_nxt = 1'b1; al_bp_nxt = mg_bp_r;
          pl_bp_nxt = mg_bp_r; pl_asize_nxt = al_asize_r; pl_from_nxt = 1'b1;
          pl_ret_nxt = al_ret_r;
          state_nxt = flha_pkg::S_PL0;
        end
      end

      // release
      flha_pkg::S_RL0: begin
        mem_ba = rl_bp_r - 32'd4;
        state_nxt = flha_pkg::S_RL1;
      end
      flha_pkg::S_RL1: begin
        st_bp_nxt = rl_bp_r; st_size_nxt = q_sz; st_alloc_nxt = 1'b0;
        st_ret_nxt = flha_pkg::S_RL2;
        state_nxt = flha_pkg::S_ST0;
      end
      flha_pkg::S_RL2: begin
        mg_bp_nxt = rl_bp_r; mg_ret_nxt = rl_ret_r;
        state_nxt = flha_pkg::S_MG0;
      end

      // reinitialize: padding, prologue, epilogue, first chunk
      flha_pkg::S_IN0: begin
        head_nxt = 20'd0;
        brk_nxt = 21'd0;
        if (eff < 21'd16) begin
          ini_ok_nxt = 1'b0;
          state_nxt = in_ret_r;
        end else begin
          mem_we = 1'b1; mem_ba = 32'd0;
          state_nxt = flha_pkg::S_IN1;
        end
      end
      flha_pkg::S_IN1: begin
        mem_we = 1'b1; mem_ba = 32'd4; mem_wdata = 32'd9;
        state_nxt = flha_pkg::S_IN2;
      end
      flha_pkg::S_IN2: begin
        mem_we = 1'b1; mem_ba = 32'd8; mem_wdata = 32'd9;
        state_nxt = flha_pkg::S_IN3;
      end
      flha_pkg::S_IN3: begin
        mem_we = 1'b1; mem_ba = 32'd12; mem_wdata = 32'd1;
        brk_nxt = 21'd16;
        state_nxt = flha_pkg::S_IN4;
      end
      flha_pkg::S_IN4: begin
        gr_size_nxt = flha_pkg::MIN_BLOCK; gr_ret_nxt = flha_pkg::S_IN5;
        state_nxt = flha_pkg::S_GR0;
      end
      flha_pkg::S_IN5: begin
        ini_ok_nxt = gr_ok_r;
        state_nxt = in_ret_r;
      end

      // reallocate
      flha_pkg::S_RA0: begin
        ra_asize_nxt = adjust({12'd0, sz_r});
        mem_ba = ptr - 32'd4;
        state_nxt = flha_pkg::S_RA1;
      end
      flha_pkg::S_RA1: begin
        ra_old_nxt = q_sz;
        ra_nb_nxt = ptr + q_sz;
        mem_ba = ptr + q_sz - 32'd4;
        state_nxt = flha_pkg::S_RA2;
      end
      flha_pkg::S_RA2: begin
        ra_na_nxt = mem_q[0];
        ra_ns_nxt = q_sz;
        if (ra_asize_r <= ra_old_r) begin
          pl_bp_nxt = ptr; pl_asize_nxt = ra_asize_r; pl_from_nxt = 1'b0;
          pl_ret_nxt = flha_pkg::S_TOP_PTR;
          state_nxt = flha_pkg::S_PL0;
        end else if (q_sz == 32'd0) begin
          // block is last: extend the heap behind it
          gr_size_nxt = align8(ra_asize_r - ra_old_r);
          gr_ret_nxt = flha_pkg::S_RA3;
          state_nxt = flha_pkg::S_GR0;
        end else begin
          state_nxt = flha_pkg::S_RA5;
        end
      end
      flha_pkg::S_RA3: begin
        mem_ba = ra_nb_r - 32'd4;
        state_nxt = flha_pkg::S_RA4;
      end
      flha_pkg::S_RA4: begin
        ra_na_nxt = mem_q[0];
        ra_ns_nxt = q_sz;
        state_nxt = flha_pkg::S_RA5;
      end
      flha_pkg::S_RA5: begin
        if (!ra_na_r && ({1'b0, ra_old_r} + {1'b0, ra_ns_r} >= {1'b0, ra_asize_r})) begin
          rm_bp_nxt = ra_nb_r; rm_ret_nxt = flha_pkg::S_RA6;
          state_nxt = flha_pkg::S_RM0;
        end else begin
          state_nxt = flha_pkg::S_RA8;
        end
      end
      flha_pkg::S_RA6: begin
        st_bp_nxt = ptr; st_size_nxt = ra_old_r + ra_ns_r; st_alloc_nxt = 1'b0;
        st_ret_nxt = flha_pkg::S_RA7;
        state_nxt = flha_pkg::S_ST0;
      end
      flha_pkg::S_RA7: begin
        pl_bp_nxt = ptr; pl_asize_nxt = ra_asize_r; pl_from_nxt = 1'b0;
        pl_ret_nxt = flha_pkg::S_TOP_PTR;
        state_nxt = flha_pkg::S_PL0;
      end
      flha_pkg::S_RA8: begin
        if (sz_r == 20'd0) begin
          res_ofs_nxt = 20'd0; res_st_nxt = flha_pkg::ST_OOM;
          state_nxt = flha_pkg::S_OUT;
        end else begin
          al_size_nxt = sz_r; al_ret_nxt = flha_pkg::S_RA9;
          state_nxt = flha_pkg::S_AL0;
        end
      end
      flha_pkg::S_RA9: begin
        if (!al_ok_r) begin
          res_ofs_nxt = 20'd0; res_st_nxt = flha_pkg::ST_OOM;
          state_nxt = flha_pkg::S_OUT;
        end else begin
          ra_np_nxt = al_bp_r;
          rl_bp_nxt = ptr; rl_ret_nxt = flha_pkg::S_RA10;
          state_nxt = flha_pkg::S_RL0;
        end
      end
      flha_pkg::S_RA10: begin
        res_ofs_nxt = ra_np_r[19:0]; res_st_nxt = flha_pkg::ST_OK;
        state_nxt = flha_pkg::S_OUT;
      end
      default: state_nxt = flha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flha_pkg::S_IN0;
      in_ret_r <= flha_pkg::S_BOOT;
      lim_r <= flha_pkg::LIMIT_RESET;
      head_r <= 20'd0;
      brk_r <= 21'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      in_ret_r <= in_ret_nxt;
      lim_r <= lim_nxt;
      head_r <= head_nxt;
      brk_r <= brk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_ret_r <= st_ret_nxt; pu_ret_r <= pu_ret_nxt; rm_ret_r <= rm_ret_nxt;
    mg_ret_r <= mg_ret_nxt; gr_ret_r <= gr_ret_nxt; pl_ret_r <= pl_ret_nxt;
    al_ret_r <= al_ret_nxt; rl_ret_r <= rl_ret_nxt;
    sz_r <= sz_nxt; off_r <= off_nxt;
    out_ofs_r <= out_ofs_nxt; out_st_r <= out_st_nxt;
    res_ofs_r <= res_ofs_nxt; res_st_r <= res_st_nxt;
    st_bp_r <= st_bp_nxt; st_size_r <= st_size_nxt; st_alloc_r <= st_alloc_nxt;
    pu_bp_r <= pu_bp_nxt; pu_old_r <= pu_old_nxt;
    rm_bp_r <= rm_bp_nxt; rm_p_r <= rm_p_nxt; rm_s_r <= rm_s_nxt;
    mg_bp_r <= mg_bp_nxt; mg_pb_r <= mg_pb_nxt; mg_nb_r <= mg_nb_nxt;
    mg_size_r <= mg_size_nxt; mg_pbs_r <= mg_pbs_nxt; mg_pa_r <= mg_pa_nxt;
    gr_bp_r <= gr_bp_nxt; gr_size_r <= gr_size_nxt; gr_ok_r <= gr_ok_nxt;
    bf_bp_r <= bf_bp_nxt; bf_best_r <= bf_best_nxt; bf_bests_r <= bf_bests_nxt;
    bf_n_r <= bf_n_nxt;
    pl_bp_r <= pl_bp_nxt; pl_asize_r <= pl_asize_nxt; pl_bs_r <= pl_bs_nxt;
    pl_from_r <= pl_from_nxt;
    al_size_r <= al_size_nxt; al_asize_r <= al_asize_nxt; al_bp_r <= al_bp_nxt;
    al_ok_r <= al_ok_nxt;
    rl_bp_r <= rl_bp_nxt; ini_ok_r <= ini_ok_nxt;
    ra_asize_r <= ra_asize_nxt; ra_old_r <= ra_old_nxt; ra_nb_r <= ra_nb_nxt;
    ra_ns_r <= ra_ns_nxt; ra_np_r <= ra_np_nxt; ra_na_r <= ra_na_nxt;
  end

endmodule

// File: test/tb.sv
// Testbench for the free-list heap allocator: stream stimulus, scoreboard against a heap model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flha_pkg::*;

  typedef bit [31:0] u32;
  typedef struct {
    bit [1:0]  op;
    bit [19:0] size;
    bit [19:0] ofs;
  } heap_req_t;
  typedef struct packed {
    bit [19:0] ofs;
    bit [1:0]  st;
  } heap_res_t;

  localparam u32 HW = 262144;
  localparam u32 MAX_NODES = HW * 4 / 24 + 1;
  localparam u32 TAG_MASK = 32'hFFFF_FFF8;
  localparam bit [2:0] REG_HEAP_LIMIT = 3'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // opcode, request_size, block_offset
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // result_offset, status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  free_list_heap_allocator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // heap mirror
  u32 heap_mem [int unsigned];
  u32 m_head, m_brk, m_lim;

  heap_req_t req_q[$];
  heap_res_t res_q[$];
  bit [19:0] live_q[$];
  int errors = 0;
  bit burst = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  wire holding = hold_go && hold_cnt < 400;

  function automatic u32 hrd(u32 a);
    int unsigned i = (a >> 2) % HW;
    return heap_mem.exists(i) ? heap_mem[i] : 32'd0;
  endfunction

  function automatic void hwr(u32 a, u32 v);
    heap_mem[(a >> 2) % HW] = v;
  endfunction

  function automatic u32 al8(u32 x);
    return (x + 32'd7) & TAG_MASK;
  endfunction

  function automatic u32 bsize(u32 bp);
    return hrd(bp - 4) & TAG_MASK;
  endfunction

  function automatic bit bused(u32 bp);
    return hrd(bp - 4) & 32'd1;
  endfunction

  function automatic void set_tag(u32 bp, u32 size, u32 used);
    u32 t = (size & TAG_MASK) | used;
    hwr(bp - 4, t);
    hwr(bp + (size & TAG_MASK) - 8, t);
  endfunction

  function automatic u32 lim_eff();
    return (m_lim > 32'd1048576) ? 32'd1048576 : m_lim;
  endfunction

  function automatic void list_push(u32 bp);
    u32 old = m_head;
    m_head = bp & 32'hFFFFF;
    hwr(bp + 4, old);
    hwr(bp, 0);
    if (old != 0) hwr(old, bp);
  endfunction

  function automatic void list_unlink(u32 bp);
    u32 p = hrd(bp);
    u32 s = hrd(bp + 4);
    if (p != 0) hwr(p + 4, s);
    else m_head = s & 32'hFFFFF;
    if (s != 0) hwr(s, p);
    hwr(bp, 0);
    hwr(bp + 4, 0);
  endfunction

  function automatic u32 coalesce(u32 bp);
    u32 pb = bp - (hrd(bp - 8) & TAG_MASK);
    u32 nb = bp + bsize(bp);
    bit pa = bused(pb);
    bit na = bused(nb);
    u32 size = bsize(bp);
    if (!pa && na) begin
      size += bsize(pb);
      list_unlink(pb);
      bp = pb;
    end else if (pa && !na) begin
      size += bsize(nb);
      list_unlink(nb);
    end else if (!pa && !na) begin
      size += bsize(pb) + bsize(nb);
      list_unlink(pb);
      list_unlink(nb);
      bp = pb;
    end
    if (!(pa && na)) set_tag(bp, size, 0);
    list_push(bp);
    return bp;
  endfunction

  function automatic u32 extend_heap(u32 bytes, output bit ok);
    u32 size = al8(bytes);
    u32 bp = m_brk;
    if (longint'(m_brk) + longint'(size) > longint'(lim_eff())) begin
      ok = 1'b0;
      return 0;
    end
    m_brk += size;
    set_tag(bp, size, 0);
    hwr(bp + size - 4, 1);
    ok = 1'b1;
    return coalesce(bp);
  endfunction

  function automatic u32 best_fit(u32 asize);
    u32 bp = m_head;
    u32 best = 0;
    u32 bs = 32'hFFFF_FFFF;
    u32 n = 0;
    u32 s;
    while (bp != 0 && n < MAX_NODES) begin
      s = bsize(bp);
      if (asize <= s && s < bs) begin
        bs = s;
        best = bp;
      end
      bp = hrd(bp + 4);
      n++;
    end
    return best;
  endfunction

  function automatic void place(u32 bp, u32 asize, bit on_list);
    u32 bs;
    if (on_list) list_unlink(bp);
    bs = bsize(bp);
    if (longint'(bs) >= longint'(asize) + 24) begin
      set_tag(bp, asize, 1);
      set_tag(bp + asize, bs - asize, 0);
      list_push(bp + asize);
    end else begin
      set_tag(bp, bs, 1);
    end
  endfunction

  function automatic u32 adj_size(u32 size);
    u32 a = al8(size + 8);
    return (a < 24) ? 32'd24 : a;
  endfunction

  function automatic u32 heap_alloc(u32 size, output bit ok);
    u32 asize, bp, ext, last, ls;
    if (size == 448) size = 512;
    if (size == 112) size = 128;
    asize = adj_size(size);
    bp = best_fit(asize);
    if (bp != 0) begin
      place(bp, asize, 1'b1);
      ok = 1'b1;
      return bp;
    end
    ext = asize;
    last = m_brk - (hrd(m_brk - 8) & TAG_MASK);
    if (!bused(last)) begin
      ls = bsize(last);
      if (ls < asize) ext = al8(asize - ls);
    end
    bp = extend_heap(ext, ok);
    if (!ok) return 0;
    place(bp, asize, 1'b1);
    return bp;
  endfunction

  function automatic void heap_release(u32 bp);
    u32 m;
    set_tag(bp, bsize(bp), 0);
    m = coalesce(bp);
  endfunction

  function automatic bit heap_init();
    bit ok;
    u32 bp;
    m_head = 0;
    m_brk = 0;
    if (lim_eff() < 16) return 1'b0;
    hwr(0, 0);
    hwr(4, 9);
    hwr(8, 9);
    hwr(12, 1);
    m_brk = 16;
    bp = extend_heap(24, ok);
    return ok;
  endfunction

  function automatic heap_res_t heap_realloc(u32 ptr, u32 size);
    heap_res_t r = '0;
    u32 asize = adj_size(size);
    u32 old = bsize(ptr);
    u32 nb = ptr + old;
    bit na = bused(nb);
    u32 ns = bsize(nb);
    u32 np, t;
    bit ok;
    if (asize <= old) begin
      place(ptr, asize, 1'b0);
      r.ofs = ptr[19:0];
      return r;
    end
    if (ns == 0) begin
      t = extend_heap(al8(asize - old), ok);
      nb = ptr + old;
      na = bused(nb);
      ns = bsize(nb);
    end
    if (!na && longint'(old) + longint'(ns) >= longint'(asize)) begin
      list_unlink(nb);
      set_tag(ptr, old + ns, 0);
      place(ptr, asize, 1'b0);
      r.ofs = ptr[19:0];
      return r;
    end
    ok = 1'b0;
    np = (size != 0) ? heap_alloc(size, ok) : 32'd0;
    if (size == 0 || !ok) begin
      r.st = ST_OOM;
      return r;
    end
    heap_release(ptr);
    r.ofs = np[19:0];
    return r;
  endfunction

  function automatic heap_res_t heap_step(bit [1:0] op, bit [19:0] size, bit [19:0] ofs);
    heap_res_t r = '0;
    bit [1:0] eop = op;
    bit ok;
    u32 a;
    if (op == OP_REALLOC && ofs == 0) eop = OP_ALLOC;
    case (eop)
      OP_ALLOC: begin
        if (size == 0) r.st = ST_NULL;
        else begin
          a = heap_alloc(u32'(size), ok);
          if (ok) r.ofs = a[19:0];
          else r.st = ST_OOM;
        end
      end
      OP_FREE: begin
        if (ofs == 0) r.st = ST_NULL;
        else heap_release(u32'(ofs));
      end
      OP_REALLOC: r = heap_realloc(u32'(ofs), u32'(size));
      default: if (!heap_init()) r.st = ST_OOM;
    endcase
    return r;
  endfunction

  function automatic void drop_live(bit [19:0] ofs);
    foreach (live_q[k]) begin
      if (live_q[k] == ofs) begin
        live_q.delete(k);
        return;
      end
    end
  endfunction

  // predict, track live blocks, queue the beat
  task automatic issue(input bit [1:0] op, input bit [19:0] size, input bit [19:0] ofs);
    heap_req_t rq;
    heap_res_t rs;
    rq.op = op;
    rq.size = size;
    rq.ofs = ofs;
    rs = heap_step(op, size, ofs);
    if (op == OP_INIT) live_q.delete();
    else if (op == OP_FREE) drop_live(ofs);
    else if (rs.st == ST_OK) begin
      if (op == OP_REALLOC && ofs != 0) drop_live(ofs);
      live_q.push_back(rs.ofs);
    end
    req_q.push_back(rq);
    res_q.push_back(rs);
  endtask

  function automatic bit [19:0] rand_size();
    int p = $urandom_range(0, 99);
    if (p < 3) begin
      case ($urandom_range(0, 2))
        0: return 20'd0;
        1: return 20'd112;
        default: return 20'd448;
      endcase
    end
    if (p < 75) return 20'($urandom_range(1, 200));
    if (p < 95) return 20'($urandom_range(201, 4000));
    return 20'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic bit [19:0] pick_live();
    return live_q.size() ? live_q[$urandom_range(0, live_q.size() - 1)] : 20'd0;
  endfunction

  task automatic issue_random();
    int r = $urandom_range(0, 99);
    if (live_q.size() > 60 && r < 45) r = 50;
    if (r < 45) issue(OP_ALLOC, rand_size(), 20'd0);
    else if (r < 78) issue(OP_FREE, 20'd0, ($urandom_range(0, 19) == 0) ? 20'd0 : pick_live());
    else if (r < 95) issue(OP_REALLOC, rand_size(), pick_live());
    else if (r < 97) issue(OP_REALLOC, rand_size(), 20'd0);
    else if (r < 99) issue(OP_ALLOC, 20'd0, 20'($urandom_range(0, 20'hFFFFF)));
    else issue(OP_INIT, 20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
  endtask

  task automatic drain();
    while (req_q.size() != 0 || res_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_limit(input bit [20:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_HEAP_LIMIT;
    cfg_pwdata <= 32'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    m_lim = 32'(v);
  endtask

  // input driver
  heap_req_t cur_req;
  int in_gap = 0;
  logic in_taken = 1'b0;
  always @(posedge clk) in_taken <= rst_n && in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        in_tdata <= {6'd0, cur_req.ofs, cur_req.size, cur_req.op};
        in_tvalid <= 1'b1;
        in_gap = burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side
  int rx_wait = 0;
  logic out_taken = 1'b0;
  heap_res_t want;

  always @(posedge clk) if (hold_go && hold_cnt < 400) hold_cnt <= hold_cnt + 1;

  always @(negedge clk) begin
    if (out_taken) rx_wait = burst ? 0 : $urandom_range(0, 15);
    if (!rst_n || holding) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (res_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = res_q.pop_front();
        if (out_tdata[19:0] !== want.ofs || out_tdata[21:20] !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: ofs exp %h got %h, status exp %0d got %0d",
                     want.ofs, out_tdata[19:0], want.st, out_tdata[21:20]);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    heap_mem.delete();
    m_lim = 32'(LIMIT_RESET);
    void'(heap_init());
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    issue(OP_ALLOC, 20'd0, 20'd0);
    issue(OP_FREE, 20'd0, 20'd0);
    issue(OP_ALLOC, 20'd1, 20'd0);
    issue(OP_ALLOC, 20'd448, 20'd0);
    issue(OP_ALLOC, 20'd112, 20'd0);
    issue(OP_ALLOC, 20'd24, 20'd0);
    issue(OP_REALLOC, 20'd0, live_q[1]);
    issue(OP_REALLOC, 20'd2000, live_q[$]);
    issue(OP_REALLOC, 20'd300, live_q[0]);
    issue(OP_REALLOC, 20'd40, 20'd0);
    issue(OP_FREE, 20'd0, live_q[1]);
    issue(OP_REALLOC, 20'd1000000, live_q[0]);
    issue(OP_ALLOC, 20'hFFFFF, 20'd0);
    issue(OP_ALLOC, 20'd600000, 20'd0);
    issue(OP_ALLOC, 20'd100000, 20'd0);
    issue(OP_FREE, 20'd0, live_q[$]);
    issue(OP_FREE, 20'd0, live_q[$]);
    issue(OP_INIT, 20'hFFFFF, 20'hFFFFF);
    drain();

    // receiver holds off while the sender keeps going
    hold_go = 1'b1;
    burst = 1'b1;
    repeat (80) issue_random();
    drain();
    burst = 1'b0;
    repeat (560) issue_random();
    drain();

    // smallest limit: reinit cannot fit the first chunk
    write_limit(21'd32);
    issue(OP_INIT, 20'd0, 20'd0);
    issue(OP_ALLOC, 20'd8, 20'd0);
    issue(OP_REALLOC, 20'd8, 20'd0);
    issue(OP_FREE, 20'd0, 20'd0);
    drain();

    write_limit(21'd4096);
    issue(OP_INIT, 20'd0, 20'd0);
    repeat (600) issue_random();
    drain();

    write_limit(LIMIT_RESET);
    issue(OP_INIT, 20'd0, 20'd0);
    repeat (300) issue_random();
    drain();
    burst = 1'b1;
    repeat (300) issue_random();
    drain();

    if (errors == 0 && res_q.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
